// ===== hdl/cpp_pkg.sv =====
// Shared types and constants for the cascaded interrupt controller pair.
// No dependencies; used by cpp_step and cascaded_pic_pair.
package cpp_pkg;

	// item kinds
	localparam logic [2:0] OP_WRITE  = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_ASSERT = 3'd2;
	localparam logic [2:0] OP_DEASRT = 3'd3;
	localparam logic [2:0] OP_PULSE  = 3'd4;
	localparam logic [2:0] OP_VECTOR = 3'd5;
	localparam logic [2:0] OP_ACK    = 3'd6;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SAT_HI = 2'd1;
	localparam logic [1:0] ST_SAT_LO = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	// mode flag bit positions
	localparam int F_READY  = 0;
	localparam int F_AEOI   = 1;
	localparam int F_POLL   = 2;
	localparam int F_ROTATE = 3;
	localparam int F_SFNM   = 4;
	localparam int F_RIS    = 5;
	localparam int F_RAISED = 6;
	localparam int F_SMM    = 7;

	// configuration register indexes and fixed-zero masks
	localparam logic REG_LVL_M = 1'b0;
	localparam logic REG_LVL_S = 1'b1;
	localparam logic [7:0] LVL_KEEP_M = 8'hf8;
	localparam logic [7:0] LVL_KEEP_S = 8'hde;

	localparam logic [2:0] CASCADE_PIN = 3'd2;

	typedef struct packed {
		logic [1:0] init_step;
		logic [7:0] flags;
		logic [7:0] irr;
		logic [7:0] isr;
		logic [7:0] imr;
		logic [4:0] base;
		logic [2:0] lp;
	} chip_t;

	typedef struct packed {
		logic [2:0] op;
		logic       chip;
		logic       port_odd;
		logic [7:0] write_data;
		logic [3:0] irq_line;
		logic [7:0] ack_vector;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] vector;
		logic [1:0] status;
		logic       cpu_intr;
	} result_t;

endpackage

// ===== hdl/cpp_step.sv =====
// Next-state and result logic for one word of the controller pair.
// Depends on cpp_pkg; instantiated by cascaded_pic_pair.
module cpp_step #(
	parameter int COUNT_WIDTH = 8
) (
	input  cpp_pkg::item_t                item,
	input  cpp_pkg::chip_t [1:0]          chips,
	input  logic [COUNT_WIDTH-1:0]        cnt_sel,
	input  logic [COUNT_WIDTH-1:0]        cnt_two,
	input  logic [15:0]                   cnt_nz,
	input  logic [7:0]                    lvl_m,
	input  logic [7:0]                    lvl_s,
	output cpp_pkg::chip_t [1:0]          chips_nxt,
	output logic [COUNT_WIDTH-1:0]        cnt_sel_nxt,
	output logic [COUNT_WIDTH-1:0]        cnt_two_nxt,
	output cpp_pkg::result_t              res
);
	localparam int CW = COUNT_WIDTH;

	typedef struct packed {
		cpp_pkg::chip_t [1:0] ch;
		logic [CW-1:0]        csel;
		logic [CW-1:0]        c2;
		logic                 raised;
	} work_t;

	// {found, pin} of the highest-priority request
	function automatic logic [3:0] irr_pin(input cpp_pkg::chip_t c);
		logic [7:0] serv;
		logic [2:0] p;
		logic       stop;
		logic [3:0] r;
		serv = c.isr;
		if (c.flags[cpp_pkg::F_SFNM]) serv[2] = 1'b0;
		if (c.flags[cpp_pkg::F_SMM]) serv = 8'h00;
		r = 4'd0;
		stop = 1'b0;
		p = c.lp + 3'd1;
		for (int i = 0; i < 8; i++) begin
			if (!stop) begin
				if (serv[p]) begin
					stop = 1'b1;
				end else if (c.irr[p] && !c.imr[p]) begin
					r = {1'b1, p};
					stop = 1'b1;
				end
			end
			p = p + 3'd1;
		end
		return r;
	endfunction

	function automatic logic [3:0] isr_pin(input cpp_pkg::chip_t c);
		logic [2:0] p;
		logic       stop;
		logic [3:0] r;
		r = 4'd0;
		stop = 1'b0;
		p = c.lp + 3'd1;
		for (int i = 0; i < 8; i++) begin
			if (!stop && c.isr[p] && !(c.flags[cpp_pkg::F_SMM] && c.imr[p])) begin
				r = {1'b1, p};
				stop = 1'b1;
			end
			p = p + 3'd1;
		end
		return r;
	endfunction

	// count and request update for one line, no cascade handling
	function automatic work_t pin_upd(input work_t wi, input logic casc,
			input logic [3:0] line, input logic up, output logic [1:0] st);
		work_t         w;
		logic [3:0]    ln;
		logic [CW-1:0] oldc;
		logic [CW-1:0] newc;
		logic          lvl;
		logic          c;
		logic [2:0]    lp;
		w = wi;
		ln = casc ? {1'b0, cpp_pkg::CASCADE_PIN} : line;
		oldc = casc ? w.c2 : w.csel;
		newc = oldc;
		st = cpp_pkg::ST_OK;
		if (up) begin
			if (oldc != '1) newc = oldc + CW'(1);
			else st = cpp_pkg::ST_SAT_HI;
		end else begin
			if (oldc != '0) newc = oldc - CW'(1);
			else st = cpp_pkg::ST_SAT_LO;
		end
		// line 2 of the master shares the cascade counter
		if (casc || line == {1'b0, cpp_pkg::CASCADE_PIN}) w.c2 = newc;
		if (!casc || line == {1'b0, cpp_pkg::CASCADE_PIN}) w.csel = newc;
		c = ln[3];
		lp = ln[2:0];
		lvl = c ? lvl_s[lp] : lvl_m[lp];
		if ((oldc == '0 && newc == CW'(1)) || (newc != '0 && lvl))
			w.ch[c].irr[lp] = 1'b1;
		else if (oldc == CW'(1) && newc == '0 && lvl)
			w.ch[c].irr[lp] = 1'b0;
		return w;
	endfunction

	function automatic work_t master_check(input work_t wi);
		work_t      w;
		logic [3:0] hp;
		w = wi;
		hp = irr_pin(w.ch[0]);
		if (!w.ch[0].flags[cpp_pkg::F_RAISED] && hp[3]) begin
			w.ch[0].flags[cpp_pkg::F_RAISED] = 1'b1;
			w.raised = 1'b1;
		end
		return w;
	endfunction

	function automatic work_t notify(input work_t wi);
		work_t      w;
		logic [3:0] hp;
		logic [1:0] st;
		logic [1:0] st2;
		w = wi;
		hp = irr_pin(w.ch[1]);
		if (!w.ch[1].flags[cpp_pkg::F_RAISED] && hp[3]) begin
			w.ch[1].flags[cpp_pkg::F_RAISED] = 1'b1;
			// pulse master pin 2
			w = pin_upd(w, 1'b1, 4'd0, 1'b1, st);
			w = master_check(w);
			if (st == cpp_pkg::ST_OK) begin
				w = pin_upd(w, 1'b1, 4'd0, 1'b0, st2);
				w = master_check(w);
			end
		end
		w = master_check(w);
		return w;
	endfunction

	function automatic work_t pin_event(input work_t wi, input logic [3:0] line,
			input logic up, output logic [1:0] st);
		work_t w;
		w = pin_upd(wi, 1'b0, line, up, st);
		w = notify(w);
		return w;
	endfunction

	function automatic work_t pin_acc(input work_t wi, input logic c, input logic [2:0] pin);
		work_t w;
		w = wi;
		w.ch[c].flags[cpp_pkg::F_RAISED] = 1'b0;
		if (!cnt_nz[{c, pin}]) w.ch[c].irr[pin] = 1'b0;
		if (w.ch[c].flags[cpp_pkg::F_AEOI]) begin
			if (w.ch[c].flags[cpp_pkg::F_ROTATE]) w.ch[c].lp = pin;
		end else begin
			w.ch[c].isr[pin] = 1'b1;
		end
		return w;
	endfunction

	function automatic work_t port_write(input work_t wi, input logic c, input logic odd,
			input logic [7:0] v, output logic [1:0] st);
		work_t      w;
		logic [3:0] hp;
		logic [2:0] p;
		w = wi;
		st = cpp_pkg::ST_OK;
		if (odd) begin
			case (w.ch[c].init_step)
				2'd1: begin
					w.ch[c].base = v[7:3];
					w.ch[c].init_step = 2'd2;
				end
				2'd2: w.ch[c].init_step = 2'd3;
				2'd3: begin
					if (!v[0]) begin
						st = cpp_pkg::ST_REJECT;
					end else begin
						w.ch[c].flags[cpp_pkg::F_AEOI] = v[1];
						if (!c) w.ch[c].flags[cpp_pkg::F_SFNM] = v[4];
						w.ch[c].init_step = 2'd0;
						w.ch[c].flags[cpp_pkg::F_READY] = 1'b1;
					end
				end
				default: w.ch[c].imr = v;
			endcase
		end else begin
			if (v[4]) begin
				// ICW1: restart initialization
				w.ch[c].flags[cpp_pkg::F_READY] = 1'b0;
				w.ch[c].init_step = 2'd0;
				w.ch[c].irr = 8'h00;
				w.ch[c].imr = 8'h00;
				w.ch[c].lp = 3'd7;
				w.ch[c].flags[cpp_pkg::F_RIS] = 1'b0;
				w.ch[c].flags[cpp_pkg::F_POLL] = 1'b0;
				w.ch[c].flags[cpp_pkg::F_SMM] = 1'b0;
				if (v[1] || !v[0]) st = cpp_pkg::ST_REJECT;
				else w.ch[c].init_step = 2'd1;
			end
			if (w.ch[c].flags[cpp_pkg::F_READY]) begin
				if (v[3]) begin
					if (v[6]) w.ch[c].flags[cpp_pkg::F_SMM] = v[5];
					if (v[1]) w.ch[c].flags[cpp_pkg::F_RIS] = v[0];
					if (v[2]) w.ch[c].flags[cpp_pkg::F_POLL] = 1'b1;
				end else begin
					w.ch[c].flags[cpp_pkg::F_ROTATE] = v[7];
					if (v[5]) begin
						// end of interrupt, specific or nonspecific
						hp = v[6] ? {1'b1, v[2:0]} : isr_pin(w.ch[c]);
						p = hp[2:0];
						if (hp[3]) begin
							w.ch[c].isr[p] = 1'b0;
							if (w.ch[c].flags[cpp_pkg::F_ROTATE]) w.ch[c].lp = p;
						end
					end else if (v[6] && w.ch[c].flags[cpp_pkg::F_ROTATE]) begin
						w.ch[c].lp = v[2:0];
					end
				end
			end
		end
		if (w.ch[c].flags[cpp_pkg::F_READY]) w = notify(w);
		return w;
	endfunction

	function automatic work_t port_read(input work_t wi, input logic c, input logic odd,
			output logic [7:0] rd);
		work_t      w;
		logic [3:0] hp;
		w = wi;
		if (w.ch[c].flags[cpp_pkg::F_POLL]) begin
			w.ch[c].flags[cpp_pkg::F_POLL] = 1'b0;
			hp = irr_pin(w.ch[c]);
			if (hp[3]) begin
				w = pin_acc(w, c, hp[2:0]);
				rd = {5'b10000, hp[2:0]};
			end else begin
				rd = 8'h00;
			end
		end else if (odd) begin
			rd = w.ch[c].imr;
		end else begin
			rd = w.ch[c].flags[cpp_pkg::F_RIS] ? w.ch[c].isr : w.ch[c].irr;
		end
		return w;
	endfunction

	work_t      w0;
	work_t      w1;
	logic [1:0] st;
	logic [1:0] st_b;
	logic [7:0] rd;
	logic [3:0] hp_m;
	logic [3:0] hp_s;
	logic [3:0] hp;
	logic       vchip;

	always_comb begin
		w0 = '{ch: chips, csel: cnt_sel, c2: cnt_two, raised: 1'b0};
		w1 = w0;
		st = cpp_pkg::ST_OK;
		st_b = cpp_pkg::ST_OK;
		rd = 8'h00;
		res = '0;
		hp_m = irr_pin(w0.ch[0]);
		hp_s = irr_pin(w0.ch[1]);
		vchip = hp_m[3] && hp_m[2:0] == cpp_pkg::CASCADE_PIN;
		hp = vchip ? hp_s : hp_m;
		case (item.op)
			cpp_pkg::OP_WRITE: w1 = port_write(w0, item.chip, item.port_odd,
					item.write_data, st);
			cpp_pkg::OP_READ: w1 = port_read(w0, item.chip, item.port_odd, rd);
			cpp_pkg::OP_ASSERT, cpp_pkg::OP_DEASRT, cpp_pkg::OP_PULSE: begin
				if (w0.ch[item.irq_line[3]].flags[cpp_pkg::F_READY]) begin
					w1 = pin_event(w0, item.irq_line, item.op != cpp_pkg::OP_DEASRT, st);
					if (item.op == cpp_pkg::OP_PULSE && st == cpp_pkg::ST_OK) begin
						w1 = pin_event(w1, item.irq_line, 1'b0, st_b);
						st = st_b;
					end
				end
			end
			cpp_pkg::OP_VECTOR: begin
				res.vector = {w0.ch[vchip].base, hp[3] ? hp[2:0] : 3'd7};
			end
			cpp_pkg::OP_ACK: begin
				if (item.ack_vector[7:3] == w0.ch[1].base) begin
					w1 = pin_acc(w0, 1'b1, item.ack_vector[2:0]);
					w1 = pin_acc(w1, 1'b0, cpp_pkg::CASCADE_PIN);
				end else begin
					w1 = pin_acc(w0, 1'b0, item.ack_vector[2:0]);
				end
				w1 = notify(w1);
			end
			default: w1 = w0;
		endcase
		res.read_data = rd;
		res.status = st;
		res.cpu_intr = w1.raised;
	end

	assign chips_nxt = w1.ch;
	assign cnt_sel_nxt = w1.csel;
	assign cnt_two_nxt = w1.c2;

endmodule

// ===== hdl/cascaded_pic_pair.sv =====
// Top level of the cascaded interrupt controller pair: handshake, state and
// configuration registers. Depends on cpp_pkg and cpp_step.
//
// Takes one request word per clock and presents one result word for each;
// each word passes the input register, then the result register. A word's
// programming, line event, priority resolution and slave-to-master cascade
// are all resolved in the single pass of cpp_step between those registers,
// so a new word is taken every cycle while the result side keeps up; a
// stalled result holds the pipeline. The user must write the level masks
// through the APB port while no word is in flight; it is not enforced.
module cascaded_pic_pair #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  cpp_pkg::item_t          req_data,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output cpp_pkg::result_t        rsp_data,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	logic                    v_s1;
	cpp_pkg::item_t          item_s1;
	logic                    rsp_valid_q;
	cpp_pkg::result_t        rsp_data_q;
	cpp_pkg::chip_t [1:0]    chip_q;
	logic [COUNT_WIDTH-1:0]  cnt_q [16];
	logic [7:0]              lvl_m_q;
	logic [7:0]              lvl_s_q;
	logic [15:0]             cnt_nz;
	logic                    adv;
	logic                    take;
	cpp_pkg::chip_t [1:0]    chips_nxt;
	logic [COUNT_WIDTH-1:0]  cnt_sel_nxt;
	logic [COUNT_WIDTH-1:0]  cnt_two_nxt;
	cpp_pkg::result_t        res;
	logic                    cfg_wr;

	assign adv = !rsp_valid_q || rsp_ready;
	assign take = adv && v_s1;
	assign req_ready = !v_s1 || adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_data_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		for (int i = 0; i < 16; i++) cnt_nz[i] = cnt_q[i] != '0;
	end

	cpp_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
		.item        (item_s1),
		.chips       (chip_q),
		.cnt_sel     (cnt_q[item_s1.irq_line]),
		.cnt_two     (cnt_q[{1'b0, cpp_pkg::CASCADE_PIN}]),
		.cnt_nz      (cnt_nz),
		.lvl_m       (lvl_m_q),
		.lvl_s       (lvl_s_q),
		.chips_nxt   (chips_nxt),
		.cnt_sel_nxt (cnt_sel_nxt),
		.cnt_two_nxt (cnt_two_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			chip_q <= '0;
			for (int i = 0; i < 16; i++) cnt_q[i] <= '0;
		end else begin
			if (req_valid && req_ready) v_s1 <= 1'b1;
			else if (adv) v_s1 <= 1'b0;
			if (adv) rsp_valid_q <= v_s1;
			if (take) begin
				chip_q <= chips_nxt;
				// line 2 is carried by the cascade counter alone
				if (item_s1.irq_line != {1'b0, cpp_pkg::CASCADE_PIN})
					cnt_q[item_s1.irq_line] <= cnt_sel_nxt;
				cnt_q[{1'b0, cpp_pkg::CASCADE_PIN}] <= cnt_two_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) item_s1 <= req_data;
		if (take) rsp_data_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_m_q <= 8'h00;
			lvl_s_q <= 8'h00;
		end else if (cfg_wr) begin
			case (paddr[2])
				cpp_pkg::REG_LVL_M: lvl_m_q <= pwdata[7:0] & cpp_pkg::LVL_KEEP_M;
				cpp_pkg::REG_LVL_S: lvl_s_q <= pwdata[7:0] & cpp_pkg::LVL_KEEP_S;
				default: lvl_m_q <= lvl_m_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cpp_pkg::REG_LVL_M: prdata = {24'h0, lvl_m_q};
			cpp_pkg::REG_LVL_S: prdata = {24'h0, lvl_s_q};
			default: prdata = 32'h0;
		endcase
	end

	a_intr_flag: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.cpu_intr |=> chip_q[0].flags[cpp_pkg::F_RAISED])
		else $error("cpu_intr without master request flag");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(chip_q))
		else $error("controller state changed without a word");

	a_reject_src: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.status == cpp_pkg::ST_REJECT |-> item_s1.op == cpp_pkg::OP_WRITE)
		else $error("init reject outside a port write");

	a_lvl_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_m_q[2:0] == 3'd0 && lvl_s_q[0] == 1'b0 && lvl_s_q[5] == 1'b0)
		else $error("fixed edge lines set to level");

endmodule
